// ===== rtl/clns_pkg.sv =====
`default_nettype none

package clns_pkg;

    // Request codes
    localparam logic [2:0] REQ_INIT    = 3'd0;
    localparam logic [2:0] REQ_CLEAR   = 3'd1;
    localparam logic [2:0] REQ_DISPLAY = 3'd2;
    localparam logic [2:0] REQ_CURSOR  = 3'd3;
    localparam logic [2:0] REQ_WRITE   = 3'd4;

    // Configuration register indexes
    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    localparam logic [2:0] ROWS_RESET = 3'd1;
    localparam logic [5:0] COLS_RESET = 6'd8;

    // Controller command bytes
    localparam logic [7:0] CMD_FUNC_2LINE  = 8'h28;
    localparam logic [7:0] CMD_FUNC_1LINE  = 8'h20;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_ENTRY       = 8'h06;
    localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
    localparam logic [7:0] ROW_OFFSET      = 8'h40;

    localparam logic [3:0] NIB_RESET = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    localparam logic [5:0] WIDE_COLUMNS = 6'd24;

    localparam logic [1:0] MASK_CTRL0 = 2'b01;
    localparam logic [1:0] MASK_CTRL1 = 2'b10;
    localparam logic [1:0] MASK_BOTH  = 2'b11;

    // Strobe steps of a run
    localparam logic [3:0] BYTE_LAST_STEP = 4'd1;
    localparam logic [3:0] INIT_BYTE_STEP = 4'd4;
    localparam logic [3:0] INIT_LAST_STEP = 4'd11;
    localparam logic [3:0] INIT_NIB2_STEP = 4'd3;
    localparam logic [1:0] INIT_CLEAR_IDX = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_SHORT = 2'd1,
        WAIT_CLEAR = 2'd2,
        WAIT_RESET = 2'd3
    } wait_t;

    // One unit of work for the back end: a single byte, or the init run
    typedef struct packed {
        logic       is_init;
        logic [1:0] mask;
        logic       rs;
        logic [7:0] data;
        logic       slow;
    } job_t;

    typedef struct packed {
        logic [1:0] mask;
        logic       rs;
        logic [3:0] nibble;
        wait_t      wait_code;
        logic       last;
    } strobe_t;

    function automatic logic [12:0] wait_value(wait_t w);
        logic [12:0] v;
        case (w)
            WAIT_NONE:  v = 13'd0;
            WAIT_SHORT: v = 13'd50;
            WAIT_CLEAR: v = 13'd1650;
            WAIT_RESET: v = 13'd4500;
            default:    v = 13'd0;
        endcase
        return v;
    endfunction

    // Command bytes that follow the reset nibbles of the init run
    function automatic logic [7:0] init_byte(logic [1:0] idx, logic [7:0] mode);
        logic [7:0] b;
        case (idx)
            2'd0:    b = mode;
            2'd1:    b = CMD_DISPLAY_ON;
            2'd2:    b = CMD_CLEAR;
            default: b = CMD_ENTRY;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/clns_front.sv =====
`default_nettype none

module clns_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [0:0]      cfg_index,
    input  wire logic [5:0]      cfg_data,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [2:0]      req_type,
    input  wire logic [1:0]      row,
    input  wire logic [5:0]      col,
    input  wire logic [7:0]      char_code,
    input  wire logic            display_on,
    output clns_pkg::job_t       job,
    output logic                 job_push,
    input  wire logic            job_full
);
    import clns_pkg::*;

    logic [2:0] rows_reg;
    logic [5:0] cols_reg;
    logic [1:0] cur_mask_reg;
    logic [1:0] cur_mask_next;

    logic       accept;
    logic       wide;
    logic [1:0] global_mask;
    logic [1:0] cursor_mask;
    logic [7:0] addr;
    logic [7:0] mode;
    logic       job_valid;

    assign cfg_ready = 1'b1;
    assign full      = job_full;
    assign accept    = push & ~job_full;

    assign wide        = cols_reg > WIDE_COLUMNS;
    assign global_mask = wide ? MASK_BOTH : MASK_CTRL0;
    assign mode        = (rows_reg > 3'd1) ? CMD_FUNC_2LINE : CMD_FUNC_1LINE;

    always_comb
    begin
        cursor_mask = MASK_CTRL0;
        if (wide)
        begin
            cursor_mask = row[1] ? MASK_CTRL1 : MASK_CTRL0;
            addr = (row[0] ? ROW_OFFSET : 8'd0) + {2'b00, col};
        end
        else if (rows_reg > 3'd2)
        begin
            // Panels of more than two rows continue row zero in row one and row two in row three.
            addr = (row[0] ? {2'b00, cols_reg} : 8'd0) + (row[1] ? ROW_OFFSET : 8'd0)
                   + {2'b00, col};
        end
        else
        begin
            addr = ((row != 2'd0) ? ROW_OFFSET : 8'd0) + {2'b00, col};
        end
    end

    always_comb
    begin
        job           = '0;
        job_valid     = 1'b1;
        cur_mask_next = cur_mask_reg;
        case (req_type)
            REQ_INIT:
            begin
                job.is_init = 1'b1;
                job.mask    = global_mask;
                job.data    = mode;
            end
            REQ_CLEAR:
            begin
                job.mask = global_mask;
                job.data = CMD_CLEAR;
                job.slow = 1'b1;
            end
            REQ_DISPLAY:
            begin
                job.mask = global_mask;
                job.data = display_on ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF;
            end
            REQ_CURSOR:
            begin
                job.mask = cursor_mask;
                job.data = CMD_SET_ADDR | {1'b0, addr[6:0]};
                if (accept)
                begin
                    cur_mask_next = cursor_mask;
                end
            end
            REQ_WRITE:
            begin
                job.mask = cur_mask_reg;
                job.rs   = 1'b1;
                job.data = char_code;
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    assign job_push = accept & job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= ROWS_RESET;
            cols_reg     <= COLS_RESET;
            cur_mask_reg <= MASK_CTRL0;
        end
        else
        begin
            cur_mask_reg <= cur_mask_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROWS: rows_reg <= cfg_data[2:0];
                    CFG_COLS: cols_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clns_job_queue.sv =====
`default_nettype none

module clns_job_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire clns_pkg::job_t  wr_job,
    output logic                 full,
    output logic                 rd_valid,
    output clns_pkg::job_t       rd_job,
    input  wire logic            rd_en
);
    import clns_pkg::*;

    job_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = count_reg == 2'(QUEUE_DEPTH);
    assign rd_valid = count_reg != 2'd0;
    assign rd_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!full || rd_en))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/clns_back.sv =====
`default_nettype none

module clns_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire clns_pkg::job_t  job,
    output logic                 job_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic [1:0]           enable_mask,
    output logic                 reg_select,
    output logic [3:0]           nibble,
    output logic [12:0]          wait_us,
    output logic                 last
);
    import clns_pkg::*;

    logic [3:0] step_reg;
    logic [3:0] step_next;

    strobe_t    oq_reg [QUEUE_DEPTH];
    logic       oq_wr_ptr_reg;
    logic       oq_rd_ptr_reg;
    logic [1:0] oq_count_reg;
    logic [1:0] oq_count_next;

    strobe_t    strobe;
    strobe_t    head;
    logic [3:0] rel_step;
    logic [1:0] byte_idx;
    logic [7:0] cur_byte;
    logic       low;
    logic       slow_low;
    logic       oq_pop;
    logic       room;
    logic       advance;

    // Strobe for the current step of the job at the head of the job queue
    always_comb
    begin
        rel_step = step_reg - INIT_BYTE_STEP;
        byte_idx = rel_step[2:1];
        cur_byte = job.is_init ? init_byte(byte_idx, job.data) : job.data;
        low      = step_reg[0];
        slow_low = job.is_init ? (byte_idx == INIT_CLEAR_IDX) : job.slow;

        strobe.mask = job.mask;
        strobe.rs   = job.rs;
        strobe.last = step_reg == (job.is_init ? INIT_LAST_STEP : BYTE_LAST_STEP);
        if (job.is_init && step_reg < INIT_BYTE_STEP)
        begin
            strobe.nibble    = (step_reg == INIT_NIB2_STEP) ? NIB_4BIT : NIB_RESET;
            strobe.wait_code = WAIT_RESET;
        end
        else
        begin
            strobe.nibble = low ? cur_byte[3:0] : cur_byte[7:4];
            if (!low)
            begin
                strobe.wait_code = WAIT_NONE;
            end
            else if (slow_low)
            begin
                strobe.wait_code = WAIT_CLEAR;
            end
            else
            begin
                strobe.wait_code = WAIT_SHORT;
            end
        end
    end

    assign oq_pop  = pop & ~empty;
    assign room    = (oq_count_reg != 2'(QUEUE_DEPTH)) | oq_pop;
    assign advance = job_valid & room;
    assign job_pop = advance & strobe.last;

    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            step_next = strobe.last ? 4'd0 : step_reg + 4'd1;
        end

        oq_count_next = oq_count_reg;
        if (advance && !oq_pop)
        begin
            oq_count_next = oq_count_reg + 2'd1;
        end
        else if (!advance && oq_pop)
        begin
            oq_count_next = oq_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            oq_wr_ptr_reg <= 1'b0;
            oq_rd_ptr_reg <= 1'b0;
            oq_count_reg  <= 2'd0;
        end
        else
        begin
            step_reg     <= step_next;
            oq_count_reg <= oq_count_next;
            if (advance)
            begin
                oq_wr_ptr_reg <= ~oq_wr_ptr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= ~oq_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            oq_reg[oq_wr_ptr_reg] <= strobe;
        end
    end

    assign head        = oq_reg[oq_rd_ptr_reg];
    assign empty       = oq_count_reg == 2'd0;
    assign enable_mask = head.mask;
    assign reg_select  = head.rs;
    assign nibble      = head.nibble;
    assign wait_us     = wait_value(head.wait_code);
    assign last        = head.last;

    a_byte_step: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && !job.is_init) |-> (step_reg <= BYTE_LAST_STEP))
        else $error("byte job step beyond its low nibble");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= INIT_LAST_STEP)
        else $error("step counter out of range");

    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (step_reg == 4'd0))
        else $error("step counter not cleared after a finished run");

    a_oq_count: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg <= 2'(QUEUE_DEPTH))
        else $error("strobe queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// The first strobe of an accepted request passes the job queue and then the strobe queue.
// One strobe per cycle leaves the back-end sequencer while the strobe queue has room; a byte
// request is two strobes, init twelve, and full deasserts while the job queue has room.
// Unknown request codes are accepted and produce no strobes.
// Reset (rst_n low, asynchronous): one row, eight columns, both queues empty and
// data writes aimed at controller zero.
`default_nettype none

module char_lcd_nibble_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  req_type,
    input  wire logic [1:0]  row,
    input  wire logic [5:0]  col,
    input  wire logic [7:0]  char_code,
    input  wire logic        display_on,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       enable_mask,
    output logic             reg_select,
    output logic [3:0]       nibble,
    output logic [12:0]      wait_us,
    output logic             last
);
    import clns_pkg::*;

    job_t front_job;
    job_t queued_job;
    logic job_push;
    logic job_full;
    logic job_valid;
    logic job_pop;

    clns_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .row        (row),
        .col        (col),
        .char_code  (char_code),
        .display_on (display_on),
        .job        (front_job),
        .job_push   (job_push),
        .job_full   (job_full)
    );

    clns_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (front_job),
        .full     (job_full),
        .rd_valid (job_valid),
        .rd_job   (queued_job),
        .rd_en    (job_pop)
    );

    clns_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (queued_job),
        .job_pop     (job_pop),
        .empty       (empty),
        .pop         (pop),
        .enable_mask (enable_mask),
        .reg_select  (reg_select),
        .nibble      (nibble),
        .wait_us     (wait_us),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== tb/char_lcd_nibble_sequencer_tb.sv =====
module char_lcd_nibble_sequencer_tb;

    import clns_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 5;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_LEN  = 6;
    localparam int HOLD_LEN    = 300;
    localparam int REPORT_MAX  = 10;
    localparam int PHASE_ITEMS = 36;

    localparam logic [12:0] US_NONE  = 13'd0;
    localparam logic [12:0] US_SHORT = 13'd50;
    localparam logic [12:0] US_CLEAR = 13'd1650;
    localparam logic [12:0] US_RESET = 13'd4500;

    // Codes past the last defined request are accepted and ignored.
    localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

    typedef struct {
        logic [1:0]  mask;
        logic        rs;
        logic [3:0]  nib;
        logic [12:0] wait_us;
        logic        last;
    } strobe_rec_t;

    class lcd_strobe_board;
        strobe_rec_t expected_q[$];
        logic [2:0]  rows;
        logic [5:0]  cols;
        logic [1:0]  cur_mask;
        int          mismatches;
        int          requests;
        int          checked;

        function new();
            rows       = ROWS_RESET;
            cols       = COLS_RESET;
            cur_mask   = MASK_CTRL0;
            mismatches = 0;
            requests   = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [5:0] data);
            if (idx == CFG_ROWS)
                rows = data[2:0];
            else
                cols = data;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_strobe(logic [1:0] m, logic rs, logic [3:0] n, logic [12:0] w);
            strobe_rec_t s;
            s.mask    = m;
            s.rs      = rs;
            s.nib     = n;
            s.wait_us = w;
            s.last    = 1'b0;
            expected_q.push_back(s);
        endfunction

        function void add_byte(logic [1:0] m, logic rs, logic [7:0] b, logic [12:0] w_low);
            add_strobe(m, rs, b[7:4], US_NONE);
            add_strobe(m, rs, b[3:0], w_low);
        endfunction

        function void note_request(logic [2:0] rq, logic [1:0] r, logic [5:0] c,
                                   logic [7:0] ch, logic on);
            logic [1:0] gmask;
            logic [7:0] addr;
            int         prior_count;
            gmask       = (cols > WIDE_COLUMNS) ? MASK_BOTH : MASK_CTRL0;
            prior_count = expected_q.size();
            requests++;
            case (rq)
                REQ_INIT:
                begin
                    repeat (3) add_strobe(gmask, 1'b0, NIB_RESET, US_RESET);
                    add_strobe(gmask, 1'b0, NIB_4BIT, US_RESET);
                    add_byte(gmask, 1'b0, (rows > 1) ? CMD_FUNC_2LINE : CMD_FUNC_1LINE,
                             US_SHORT);
                    add_byte(gmask, 1'b0, CMD_DISPLAY_ON, US_SHORT);
                    add_byte(gmask, 1'b0, CMD_CLEAR, US_CLEAR);
                    add_byte(gmask, 1'b0, CMD_ENTRY, US_SHORT);
                end
                REQ_CLEAR:
                    add_byte(gmask, 1'b0, CMD_CLEAR, US_CLEAR);
                REQ_DISPLAY:
                    add_byte(gmask, 1'b0, on ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF, US_SHORT);
                REQ_CURSOR:
                begin
                    if (cols > WIDE_COLUMNS)
                    begin
                        cur_mask = r[1] ? MASK_CTRL1 : MASK_CTRL0;
                        addr = (r[0] ? ROW_OFFSET : 8'd0) + {2'b00, c};
                    end
                    else
                    begin
                        cur_mask = MASK_CTRL0;
                        if (rows > 2)
                            addr = (r[0] ? {2'b00, cols} : 8'd0) +
                                   (r[1] ? ROW_OFFSET : 8'd0) + {2'b00, c};
                        else
                            addr = ((r != 2'd0) ? ROW_OFFSET : 8'd0) + {2'b00, c};
                    end
                    add_byte(cur_mask, 1'b0, CMD_SET_ADDR | {1'b0, addr[6:0]}, US_SHORT);
                end
                REQ_WRITE:
                    add_byte(cur_mask, 1'b1, ch, US_SHORT);
                default:
                    ;
            endcase
            if (expected_q.size() > prior_count)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_strobe(logic [1:0] m, logic rs, logic [3:0] n, logic [12:0] w,
                                   logic lst);
            strobe_rec_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected strobe mask=%0d rs=%0d nibble=%h %s%0d last=%0d",
                             m, rs, n, "wait=", w, lst);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (m !== e.mask || rs !== e.rs || n !== e.nib || w !== e.wait_us ||
                lst !== e.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("ERROR: strobe %0d expected mask=%0d rs=%0d nibble=%h %s%0d last=%0d",
                             checked, e.mask, e.rs, e.nib, "wait=", e.wait_us, e.last);
                    $display("       got mask=%0d rs=%0d nibble=%h wait=%0d last=%0d",
                             m, rs, n, w, lst);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        push;
    logic        full;
    logic [2:0]  req_type;
    logic [1:0]  row;
    logic [5:0]  col;
    logic [7:0]  char_code;
    logic        display_on;
    logic        empty;
    logic        pop;
    logic [1:0]  enable_mask;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [12:0] wait_us;
    logic        last;

    lcd_strobe_board board;
    bit          src_calm;
    bit          sink_calm;
    int          sink_hold;
    int          cycle_count;
    int          cfg_writes;
    int          full_stalls;

    char_lcd_nibble_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .row         (row),
        .col         (col),
        .char_code   (char_code),
        .display_on  (display_on),
        .empty       (empty),
        .pop         (pop),
        .enable_mask (enable_mask),
        .reg_select  (reg_select),
        .nibble      (nibble),
        .wait_us     (wait_us),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d strobes still expected",
                     cycle_count, board.pending());
            $display("char_lcd_nibble_sequencer regression: fail");
            $finish;
        end
    end

    // Transfers are taken from the values present just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                board.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (push && !full)
                board.note_request(req_type, row, col, char_code, display_on);
            if (push && full)
                full_stalls++;
            if (pop && !empty)
                board.check_strobe(enable_mask, reg_select, nibble, wait_us, last);
        end
    end

    initial
    begin : result_sink
        int gap;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold > 0)
            begin
                pop <= 1'b0;
                while (sink_hold > 0)
                begin
                    @(posedge clk);
                    sink_hold--;
                end
            end
            gap = sink_calm ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    task automatic send_request(input logic [2:0] rq, input logic [1:0] r,
                                input logic [5:0] c, input logic [7:0] ch, input logic on);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type   <= rq;
        row        <= r;
        col        <= c;
        char_code  <= ch;
        display_on <= on;
        push       <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic random_request();
        int         pick;
        logic [2:0] rq;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            rq = REQ_INIT;
        else if (pick < 15)
            rq = REQ_CLEAR;
        else if (pick < 25)
            rq = REQ_DISPLAY;
        else if (pick < 55)
            rq = REQ_CURSOR;
        else if (pick < 94)
            rq = REQ_WRITE;
        else
            rq = 3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
        send_request(rq, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Stop offering requests and let every expected strobe come out. The first edge
    // makes sure the monitor has noted the request transferred at the previous one.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Unknown codes leave no strobe behind, so let the bench settle after draining before a write.
    task automatic set_panel(input logic [2:0] rows_val, input logic [5:0] cols_val);
        drain_results();
        repeat (SETTLE_LEN) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= {3'($urandom_range(0, 7)), rows_val};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_COLS;
        cfg_data  <= cols_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [2:0] phase_rows[8];
        logic [5:0] phase_cols[8];
        int         p;
        int         n;
        board       = new();
        cycle_count = 0;
        cfg_writes  = 0;
        full_stalls = 0;
        sink_hold   = 0;
        src_calm    = 1'b0;
        sink_calm   = 1'b0;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_ROWS;
        cfg_data   <= '0;
        push       <= 1'b0;
        req_type   <= REQ_INIT;
        row        <= '0;
        col        <= '0;
        char_code  <= '0;
        display_on <= 1'b0;
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one row, eight columns, writes aimed at controller zero.
        send_request(REQ_WRITE, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_INIT, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_CLEAR, 2'd3, 6'd63, 8'hFF, 1'b1);
        send_request(REQ_DISPLAY, 2'd0, 6'd0, 8'h00, 1'b1);
        send_request(REQ_DISPLAY, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_CURSOR, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_CURSOR, 2'd1, 6'd63, 8'h00, 1'b0);
        send_request(REQ_CURSOR, 2'd3, 6'd63, 8'h00, 1'b0);
        send_request(REQ_WRITE, 2'd0, 6'd0, 8'hFF, 1'b0);
        send_request(REQ_WRITE, 2'd3, 6'd63, 8'h5A, 1'b1);
        send_request(3'd5, 2'd3, 6'd63, 8'hFF, 1'b1);
        send_request(3'd6, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_BAD_LAST, 2'd1, 6'd21, 8'hA5, 1'b1);

        // Two controllers: a cursor on the lower half steers the next write there.
        set_panel(3'd2, 6'd40);
        send_request(REQ_INIT, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_CURSOR, 2'd2, 6'd5, 8'h00, 1'b0);
        send_request(REQ_WRITE, 2'd0, 6'd0, 8'hC3, 1'b0);
        send_request(REQ_CURSOR, 2'd3, 6'd63, 8'h00, 1'b0);
        send_request(REQ_WRITE, 2'd0, 6'd0, 8'h3C, 1'b0);
        send_request(REQ_CLEAR, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_DISPLAY, 2'd0, 6'd0, 8'h00, 1'b0);
        send_request(REQ_CURSOR, 2'd1, 6'd0, 8'h00, 1'b0);
        send_request(REQ_WRITE, 2'd0, 6'd0, 8'h81, 1'b0);

        phase_rows = '{3'd4, 3'd4, 3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd2};
        phase_cols = '{6'd20, 6'd40, 6'd0, 6'd63, 6'd24, 6'd25, 6'd1, 6'd16};
        for (p = 0; p < 8; p++)
        begin
            set_panel(phase_rows[p], phase_cols[p]);
            src_calm  = (p % 3 == 1);
            sink_calm = (p % 4 == 2);
            // The sink stalls while requests keep coming, so the queues fill up.
            if (p == 1)
                sink_hold = HOLD_LEN;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 4 && n == PHASE_ITEMS / 2)
                    drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (SETTLE_LEN) @(posedge clk);
        $display("covered %0d requests, %0d strobes checked, %0d register writes",
                 board.requests, board.checked, cfg_writes);
        $display("%0d cycles with the input held off by a full queue, %0d mismatches",
                 full_stalls, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("char_lcd_nibble_sequencer regression: pass");
        else
            $display("char_lcd_nibble_sequencer regression: fail");
        $finish;
    end

endmodule
